@@ hdl/lcg48_jump_ahead_generator_defines.svh @@
// assertion macros for the lcg48 generator
`ifndef LCG48_JUMP_AHEAD_GENERATOR_DEFINES_SVH
`define LCG48_JUMP_AHEAD_GENERATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LCG48_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LCG48_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lcg48_pkg.sv @@
`timescale 1ns / 1ps

package lcg48_pkg;

    localparam int VALUE_W = 48;
    localparam int INC_W   = 16;

    // register reset values
    localparam logic [VALUE_W-1:0] MULT_RESET = 48'h0005_DEEC_E66D;
    localparam logic [INC_W-1:0]   INC_RESET  = 16'h000B;
    localparam logic [VALUE_W-1:0] SEED_RESET = 48'h330E_ABCD_1234;

    // configuration register indices
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd2;

    // multiply-add unit: one 16-bit digit of the b operand per cycle
    localparam int MAC_DIGIT_W = 16;
    localparam int MAC_STEPS   = VALUE_W / MAC_DIGIT_W;
    localparam int MAC_CNT_W   = 2;

    // datapath operations
    typedef enum logic [2:0] {
        OP_ADV   = 3'd0,  // x*a + c
        OP_MUL   = 3'd1,  // mul*h
        OP_ADD   = 3'd2,  // add*h + f
        OP_FSTEP = 3'd3,  // f*(h+1)
        OP_HSQR  = 3'd4,  // h*h
        OP_FIN   = 3'd5   // seed*mul + add
    } t_op;

    typedef struct packed {
        logic                action;
        logic [VALUE_W-1:0]  skip_count;
    } t_in_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  value48;
        logic [30:0]         unsigned31;
        logic signed [31:0]  signed32;
    } t_out_res;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mac_start;
        t_op  op;
        logic wb;
        logic n_shift;
        logic out_write;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mac_busy;
        logic mac_done;
        logic n_zero;
        logic n_bit0;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/lcg48_mac.sv @@
`timescale 1ns / 1ps

module lcg48_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lcg48_pkg::VALUE_W-1:0] i_a,
    input  logic [lcg48_pkg::VALUE_W-1:0] i_b,
    input  logic [lcg48_pkg::VALUE_W-1:0] i_addend,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [lcg48_pkg::VALUE_W-1:0] o_acc
);

    logic [lcg48_pkg::VALUE_W-1:0]   r_a;
    logic [lcg48_pkg::VALUE_W-1:0]   r_b;
    logic [lcg48_pkg::VALUE_W-1:0]   r_acc;
    logic [lcg48_pkg::MAC_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic [lcg48_pkg::VALUE_W+lcg48_pkg::MAC_DIGIT_W-1:0] prod;

    // one 48x16 partial product per cycle
    assign prod   = r_a * r_b[lcg48_pkg::MAC_DIGIT_W-1:0];
    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == lcg48_pkg::MAC_CNT_W'(lcg48_pkg::MAC_STEPS - 1));
    assign o_acc  = r_acc;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand shifting and accumulation, kept modulo 2^48
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= i_addend;
        end else if (r_busy) begin
            r_a   <= r_a << lcg48_pkg::MAC_DIGIT_W;
            r_b   <= r_b >> lcg48_pkg::MAC_DIGIT_W;
            r_acc <= r_acc + prod[lcg48_pkg::VALUE_W-1:0];
        end
    end

endmodule

@@ hdl/lcg48_dp.sv @@
`timescale 1ns / 1ps

module lcg48_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcg48_pkg::t_cmd               i_cmd,
    output lcg48_pkg::t_sts               o_sts,
    input  lcg48_pkg::t_in_req            i_in_data,
    input  logic                          i_cfg_wr_en,
    input  logic [lcg48_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lcg48_pkg::VALUE_W-1:0] i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output lcg48_pkg::t_out_res           o_out_data
);

    localparam int W = lcg48_pkg::VALUE_W;

    logic [W-1:0]                r_multiplier;
    logic [lcg48_pkg::INC_W-1:0] r_increment;
    logic [W-1:0]                r_seed;
    logic [W-1:0]                r_x;
    logic [W-1:0]                r_mul;
    logic [W-1:0]                r_add;
    logic [W-1:0]                r_h;
    logic [W-1:0]                r_f;
    logic [W-1:0]                r_n;
    logic                        r_out_valid;
    lcg48_pkg::t_out_res         r_out;

    logic [W-1:0] cur;
    logic [W-1:0] op_a;
    logic [W-1:0] op_b;
    logic [W-1:0] op_add;
    logic         mac_busy;
    logic         mac_done;
    logic [W-1:0] mac_acc;

    // current state, forwarded when it is written in the same cycle
    assign cur = i_cmd.out_write ? mac_acc : r_x;

    // operand selection per operation
    always_comb begin
        op_a   = r_h;
        op_b   = r_h;
        op_add = '0;
        case (i_cmd.op)
            lcg48_pkg::OP_ADV: begin
                op_a   = r_multiplier;
                op_b   = cur;
                op_add = W'(r_increment);
            end
            lcg48_pkg::OP_MUL: begin
                op_a = r_mul;
            end
            lcg48_pkg::OP_ADD: begin
                op_a   = r_add;
                op_add = r_f;
            end
            lcg48_pkg::OP_FSTEP: begin
                op_a = r_f;
                op_b = r_h + W'(1);
            end
            lcg48_pkg::OP_HSQR: begin
                op_a = r_h;
            end
            lcg48_pkg::OP_FIN: begin
                op_a   = r_seed;
                op_b   = r_mul;
                op_add = r_add;
            end
            default: begin
                op_a = r_h;
            end
        endcase
    end

    lcg48_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mac_start),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_addend (op_add),
        .o_busy   (mac_busy),
        .o_done   (mac_done),
        .o_acc    (mac_acc)
    );

    // configuration, state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiplier <= lcg48_pkg::MULT_RESET;
            r_increment  <= lcg48_pkg::INC_RESET;
            r_seed       <= lcg48_pkg::SEED_RESET;
            r_x          <= lcg48_pkg::SEED_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lcg48_pkg::CFG_MULTIPLIER: r_multiplier <= i_cfg_data;
                    lcg48_pkg::CFG_INCREMENT:  r_increment  <= i_cfg_data[lcg48_pkg::INC_W-1:0];
                    lcg48_pkg::CFG_SEED:       r_seed       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_write) begin
                r_x         <= mac_acc;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // jump-ahead working registers and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_data.action) begin
            r_mul <= W'(1);
            r_add <= '0;
            r_h   <= r_multiplier;
            r_f   <= W'(r_increment);
            r_n   <= i_in_data.skip_count;
        end else begin
            if (i_cmd.wb) begin
                case (i_cmd.op)
                    lcg48_pkg::OP_MUL:   r_mul <= mac_acc;
                    lcg48_pkg::OP_ADD:   r_add <= mac_acc;
                    lcg48_pkg::OP_FSTEP: r_f   <= mac_acc;
                    lcg48_pkg::OP_HSQR:  r_h   <= mac_acc;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.n_shift) begin
                r_n <= r_n >> 1;
            end
        end
        if (i_cmd.out_write) begin
            r_out.value48    <= mac_acc;
            r_out.unsigned31 <= mac_acc[W-1:17];
            r_out.signed32   <= signed'(mac_acc[W-1:16]);
        end
    end

    assign o_sts.mac_busy = mac_busy;
    assign o_sts.mac_done = mac_done;
    assign o_sts.n_zero   = (r_n == '0);
    assign o_sts.n_bit0   = r_n[0];
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/lcg48_ctrl.sv @@
`timescale 1ns / 1ps

module lcg48_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_action,
    output logic            o_in_stall,
    input  lcg48_pkg::t_sts i_sts,
    output lcg48_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECIDE = 6'b000010,
        ST_ISSUE  = 6'b000100,
        ST_WAIT   = 6'b001000,
        ST_WB     = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    lcg48_pkg::t_op  r_op;
    lcg48_pkg::t_op  n_op;
    logic            accept_ok;
    logic            accept;

    // requests are taken when idle or while the last result is written out
    assign accept_ok  = (r_state == ST_IDLE) || ((r_state == ST_OUT) && i_sts.out_free);
    assign accept     = i_in_valid && accept_ok;
    assign o_in_stall = !accept_ok;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (!i_in_action) begin
                        o_cmd.mac_start = 1'b1;
                        o_cmd.op        = lcg48_pkg::OP_ADV;
                        n_op            = lcg48_pkg::OP_ADV;
                        n_state         = ST_WAIT;
                    end else begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (i_sts.n_zero) begin
                    n_op = lcg48_pkg::OP_FIN;
                end else if (i_sts.n_bit0) begin
                    n_op = lcg48_pkg::OP_MUL;
                end else begin
                    n_op = lcg48_pkg::OP_FSTEP;
                end
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                o_cmd.mac_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.mac_done) begin
                    if ((r_op == lcg48_pkg::OP_ADV) || (r_op == lcg48_pkg::OP_FIN)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_WB;
                    end
                end
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = ST_ISSUE;
                case (r_op)
                    lcg48_pkg::OP_MUL:   n_op = lcg48_pkg::OP_ADD;
                    lcg48_pkg::OP_ADD:   n_op = lcg48_pkg::OP_FSTEP;
                    lcg48_pkg::OP_FSTEP: n_op = lcg48_pkg::OP_HSQR;
                    lcg48_pkg::OP_HSQR: begin
                        o_cmd.n_shift = 1'b1;
                        n_state       = ST_DECIDE;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = ST_IDLE;
                    if (accept) begin
                        o_cmd.accept = 1'b1;
                        if (!i_in_action) begin
                            o_cmd.mac_start = 1'b1;
                            o_cmd.op        = lcg48_pkg::OP_ADV;
                            n_op            = lcg48_pkg::OP_ADV;
                            n_state         = ST_WAIT;
                        end else begin
                            n_state = ST_DECIDE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= lcg48_pkg::OP_ADV;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

@@ hdl/lcg48_jump_ahead_generator.sv @@
// advance request: result registered after the three 16-bit digit steps of the shared 48x16
// multiply-add unit; the next request can be accepted while that result is written out
// seek request: mul and add for each set bit, fstep and hsqr for each bit of skip_count up to
// its top set bit, then fin; every multiply of the jump goes through the same multiply-add unit
// synchronous active-low reset: registers return to their defaults, state to the seed default
`timescale 1ns / 1ps
`include "lcg48_jump_ahead_generator_defines.svh"

module lcg48_jump_ahead_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lcg48_pkg::t_in_req              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lcg48_pkg::t_out_res             o_out_data,
    input  logic                            i_cfg_wr_en,
    input  logic [lcg48_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lcg48_pkg::VALUE_W-1:0]   i_cfg_data
);

    lcg48_pkg::t_cmd cmd;
    lcg48_pkg::t_sts sts;

    // sequencer
    lcg48_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // registers, multiply-add unit and output stage
    lcg48_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // multiply-add unit is never restarted mid-operation
    `LCG48_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, cmd.mac_start, !sts.mac_busy, "mac restarted while busy")
    // a result never overwrites one still waiting
    `LCG48_ASSERT_NOW(a_out_no_overwrite, i_clk, i_rst_n, cmd.out_write, sts.out_free, "output overwritten")
    // an accepted advance request starts the multiply-add unit
    `LCG48_ASSERT_NEXT(a_adv_starts_mac, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_in_data.action, sts.mac_busy, "advance did not start mac")

endmodule

@@ bench/lcg48_jump_ahead_generator_tb.sv @@
`timescale 1ns / 1ps

module lcg48_jump_ahead_generator_tb;

    localparam int VALUE_W   = lcg48_pkg::VALUE_W;
    localparam int INC_W     = lcg48_pkg::INC_W;
    localparam int CFG_IDX_W = lcg48_pkg::CFG_IDX_W;

    // request actions and the register index that the block leaves unmapped
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_SEEK    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic [VALUE_W-1:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;
    localparam int RANDOM_PER_PHASE = 98;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES     = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    lcg48_pkg::t_in_req    in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    lcg48_pkg::t_out_res   out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [VALUE_W-1:0]    cfg_data = '0;

    // generator model: registers and running state
    logic [VALUE_W-1:0] model_mult  = lcg48_pkg::MULT_RESET;
    logic [INC_W-1:0]   model_inc   = lcg48_pkg::INC_RESET;
    logic [VALUE_W-1:0] model_seed  = lcg48_pkg::SEED_RESET;
    logic [VALUE_W-1:0] model_state = lcg48_pkg::SEED_RESET;

    lcg48_pkg::t_in_req  pending_requests[$];
    lcg48_pkg::t_out_res expected_outputs[$];
    lcg48_pkg::t_out_res want_res;
    lcg48_pkg::t_out_res pred_res;

    int requests_queued   = 0;
    int requests_accepted = 0;
    int seeks_accepted    = 0;
    int results_checked   = 0;
    int register_writes   = 0;
    int errors            = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_off_requests = 0;
    int hold_off_served   = 0;
    int hold_off_left     = 0;
    int quiet_cycles      = 0;

    lcg48_jump_ahead_generator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // seed jumped n steps ahead by squaring the step map once per bit of n
    function automatic logic [VALUE_W-1:0] jump_from_seed(input logic [VALUE_W-1:0] start,
                                                          input logic [VALUE_W-1:0] a,
                                                          input logic [VALUE_W-1:0] c,
                                                          input logic [VALUE_W-1:0] n);
        logic [VALUE_W-1:0] mul;
        logic [VALUE_W-1:0] add;
        logic [VALUE_W-1:0] h;
        logic [VALUE_W-1:0] f;
        logic [VALUE_W-1:0] k;
        mul = 48'd1;
        add = '0;
        h = a;
        f = c;
        k = n;
        while (k != 0) begin
            if (k[0]) begin
                mul = mul * h;
                add = add * h + f;
            end
            f = f * (h + 48'd1);
            h = h * h;
            k = k >> 1;
        end
        return start * mul + add;
    endfunction

    // new state for one request, with the outputs cut from it
    function automatic lcg48_pkg::t_out_res next_generator_output(input lcg48_pkg::t_in_req req);
        logic [VALUE_W-1:0] x;
        lcg48_pkg::t_out_res res;
        if (req.action == ACT_SEEK) begin
            x = jump_from_seed(model_seed, model_mult, {32'd0, model_inc}, req.skip_count);
        end else begin
            x = model_mult * model_state + {32'd0, model_inc};
        end
        model_state = x;
        res.value48 = x;
        res.unsigned31 = x[47:17];
        res.signed32 = x[47:16];
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[VALUE_W-1:0];
    endfunction

    task automatic queue_request(input logic action, input logic [VALUE_W-1:0] skip);
        lcg48_pkg::t_in_req req;
        req.action = action;
        req.skip_count = skip;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // mostly advances; seeks mostly short, some long or sparse
    task automatic queue_random_request();
        int kind;
        if ($urandom_range(99) < 80) begin
            queue_request(ACT_ADVANCE, rand48());
        end else begin
            kind = $urandom_range(9);
            if (kind < 6)
                queue_request(ACT_SEEK, 48'($urandom_range(40)));
            else if (kind < 8)
                queue_request(ACT_SEEK, rand48());
            else if (kind == 8)
                queue_request(ACT_SEEK, ALL_ONES48);
            else
                queue_request(ACT_SEEK, 48'd1 << $urandom_range(47));
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            lcg48_pkg::CFG_MULTIPLIER: model_mult = data;
            lcg48_pkg::CFG_INCREMENT:  model_inc = data[INC_W-1:0];
            lcg48_pkg::CFG_SEED:       model_seed = data;
            default: ;
        endcase
        register_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (results_checked != requests_queued)
            @(posedge clk);
    endtask

    task automatic set_registers(input logic [VALUE_W-1:0] mult,
                                 input logic [VALUE_W-1:0] inc,
                                 input logic [VALUE_W-1:0] seed);
        wait_for_results();
        write_register(lcg48_pkg::CFG_MULTIPLIER, mult);
        write_register(lcg48_pkg::CFG_INCREMENT, inc);
        write_register(lcg48_pkg::CFG_SEED, seed);
    endtask

    // request driver: holds a stalled request, otherwise offers the next one or idles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                pred_res = next_generator_output(in_data);
                expected_outputs.push_back(pred_res);
                requests_accepted++;
                if (in_data.action == ACT_SEEK)
                    seeks_accepted++;
            end
            if (!(in_valid && in_stall)) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_outputs.size() == 0) begin
                    $error("unexpected result value48=%h", out_data.value48);
                    errors++;
                end else begin
                    want_res = expected_outputs.pop_front();
                    results_checked++;
                    if (out_data.value48 !== want_res.value48) begin
                        $error("value48 expected %h got %h", want_res.value48, out_data.value48);
                        errors++;
                    end
                    if (out_data.unsigned31 !== want_res.unsigned31) begin
                        $error("unsigned31 expected %h got %h",
                               want_res.unsigned31, out_data.unsigned31);
                        errors++;
                    end
                    if (out_data.signed32 !== want_res.signed32) begin
                        $error("signed32 expected %0d got %0d",
                               want_res.signed32, out_data.signed32);
                        errors++;
                    end
                end
            end
            if (hold_off_left > 0) begin
                out_stall <= 1'b1;
                hold_off_left--;
            end else if (hold_off_served != hold_off_requests) begin
                hold_off_served++;
                hold_off_left = HOLD_OFF_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, field extremes, zero skip
        queue_request(ACT_ADVANCE, '0);
        queue_request(ACT_ADVANCE, ALL_ONES48);
        queue_request(ACT_SEEK, '0);
        queue_request(ACT_SEEK, 48'd1);
        queue_request(ACT_SEEK, 48'd2);
        queue_request(ACT_SEEK, ALL_ONES48);
        queue_request(ACT_SEEK, 48'h8000_0000_0000);
        queue_request(ACT_SEEK, 48'h5555_5555_5555);
        queue_request(ACT_SEEK, 48'hAAAA_AAAA_AAAA);
        queue_request(ACT_ADVANCE, 48'h1234_5678_9ABC);

        // new seed leaves the running state alone until a seek
        wait_for_results();
        write_register(lcg48_pkg::CFG_SEED, rand48());
        queue_request(ACT_ADVANCE, '0);
        queue_request(ACT_SEEK, '0);

        // unmapped index ignored, increment masked to its width, extreme registers
        wait_for_results();
        write_register(CFG_UNMAPPED, ALL_ONES48);
        write_register(lcg48_pkg::CFG_INCREMENT, 48'hABCD_1234_FFFF);
        write_register(lcg48_pkg::CFG_MULTIPLIER, ALL_ONES48);
        write_register(lcg48_pkg::CFG_SEED, '0);
        queue_request(ACT_ADVANCE, rand48());
        queue_request(ACT_SEEK, 48'd3);
        queue_request(ACT_SEEK, ALL_ONES48);

        set_registers('0, '0, ALL_ONES48);
        queue_request(ACT_ADVANCE, '0);
        queue_request(ACT_SEEK, 48'd5);
        queue_request(ACT_ADVANCE, ALL_ONES48);

        set_registers(48'd1, 48'hFFFF, rand48());
        queue_request(ACT_SEEK, ALL_ONES48);
        queue_request(ACT_ADVANCE, '0);

        // random phase with no idling, opened by a long output hold-off
        set_registers(rand48(), 48'($urandom_range(16'hFFFF)), rand48());
        hold_off_requests++;
        for (int i = 0; i < 40; i++)
            queue_request(ACT_ADVANCE, rand48());
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_request();

        // sender mostly idle, extreme registers
        set_registers(ALL_ONES48, 48'hFFFF, ALL_ONES48);
        send_idle_pct = 81;
        recv_stall_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_request();

        // receiver mostly stalling; sender pauses halfway for all results
        set_registers(rand48(), 48'($urandom_range(16'hFFFF)), rand48());
        send_idle_pct = 0;
        recv_stall_pct = 81;
        for (int i = 0; i < RANDOM_PER_PHASE / 2; i++)
            queue_random_request();
        wait_for_results();
        for (int i = 0; i < RANDOM_PER_PHASE / 2; i++)
            queue_random_request();

        // light idling on both sides, reset register values
        set_registers(lcg48_pkg::MULT_RESET, 48'(lcg48_pkg::INC_RESET), lcg48_pkg::SEED_RESET);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_request();

        // random registers, no idling
        set_registers(rand48(), 48'($urandom_range(16'hFFFF)), rand48());
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_request();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_outputs.size() != 0) begin
            $error("%0d expected results never arrived", expected_outputs.size());
            errors++;
        end
        $display("run covered %0d requests (%0d seeks) and %0d register writes",
                 requests_accepted, seeks_accepted, register_writes);
        $display("across idle, stall and hold-off phases; %0d mismatches", errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ lcg48_jump_ahead_generator.f @@
+incdir+hdl
hdl/lcg48_pkg.sv
hdl/lcg48_mac.sv
hdl/lcg48_dp.sv
hdl/lcg48_ctrl.sv
hdl/lcg48_jump_ahead_generator.sv
bench/lcg48_jump_ahead_generator_tb.sv
